FILE: rtl/srr_pkg.sv
package srr_pkg;

	// Table geometry and chunk size.
	localparam int MAX_CHUNKS = 64;
	localparam int ADDR_W     = 48;
	localparam int IDX_W      = $clog2(MAX_CHUNKS);
	localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
	localparam int TOTAL_W    = 7;

	localparam logic [ADDR_W:0] CHUNK_SIZE = (ADDR_W + 1)'(1048576);

	// Command codes.
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	// Status codes.
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_NOT_FOUND = 2'd2;

	// True when address a lies in the chunk that starts at base b.
	function automatic logic in_chunk(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
		logic [ADDR_W-1:0] diff;
		diff = a - b;
		return (a >= b) && ({1'b0, diff} < CHUNK_SIZE);
	endfunction

endpackage

FILE: rtl/srr_req_if.sv
interface srr_req_if
	import srr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [ADDR_W-1:0] addr;

	modport source (output valid, output cmd, output addr, input ready);
	modport sink   (input valid, input cmd, input addr, output ready);
endinterface

FILE: rtl/srr_rsp_if.sv
interface srr_rsp_if
	import srr_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [1:0]         status;
	logic [TOTAL_W-1:0] entry_total;

	modport source (output valid, output hit, output status, output entry_total, input ready);
	modport sink   (input valid, input hit, input status, input entry_total, output ready);
endinterface

FILE: rtl/sorted_range_registry_core.sv
// Sorted range registry.
// The block keeps a sorted table of chunk base addresses; every chunk spans
// one fixed chunk size upward from its base. Items arrive on the req channel
// (cmd, addr) and every item produces exactly one item on the rsp channel
// (hit, status, entry_total). An add inserts the base in sorted order ahead
// of equal bases, a remove deletes the first equal base, and a query checks
// the most recently hit chunk before it searches the table.
// One item is worked on at a time. A single compare unit and the table's
// one read port carry a binary search; each step reads the middle entry in
// one state and compares it in the next. A query that hits the recent chunk
// skips the search. An add or a remove then moves the entries behind the
// insert or delete point by one place each cycle. The block is ready again
// in the same cycle in which the result appears in the output register.
// The result sits in an output register; the block takes the next item
// while that register still waits, and it only stalls at the end of the
// following item if the receiver has not taken the earlier result.
// Reset empties the table and forgets the recent chunk at once; the table
// memory itself is not cleared, since only entries below the count are used.
module sorted_range_registry_core
	import srr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srr_req_if.sink    req,
	srr_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_SRCH,
		S_CMP,
		S_RESOLVE,
		S_QCHK,
		S_RMCHK,
		S_SHDN,
		S_INS,
		S_SHUP,
		S_DONE
	} state_t;

	state_t state_q;

	logic [1:0]         cmd_q;
	logic [ADDR_W-1:0]  key_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  recent_base_q;
	logic               recent_valid_q;
	logic               res_hit_q;
	logic [1:0]         res_status_q;

	logic               rsp_valid_q;
	logic               rsp_hit_q;
	logic [1:0]         rsp_status_q;
	logic [TOTAL_W-1:0] rsp_total_q;

	// Table storage: one write and one registered read per cycle.
	logic [ADDR_W-1:0]  mem [MAX_CHUNKS];
	logic [ADDR_W-1:0]  rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]  wr_data;
	logic               wr_en;

	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid;
	logic [CNT_W-1:0]   mid_p1;
	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   lo_m1;
	logic [CNT_W-1:0]   lo_p1;
	logic [CNT_W-1:0]   idx_m1;
	logic [CNT_W-1:0]   idx_m2;
	logic [CNT_W-1:0]   idx_p1;
	logic [CNT_W-1:0]   idx_p2;
	logic               rd_lt;
	logic               rd_eq;
	logic               go_right;
	logic [ADDR_W-1:0]  chk_base;
	logic               chk_hit;

	// Index arithmetic for the search and the entry moves.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign mid_p1  = mid + CNT_W'(1);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign lo_m1   = lo_q - CNT_W'(1);
	assign lo_p1   = lo_q + CNT_W'(1);
	assign idx_m1  = idx_q - CNT_W'(1);
	assign idx_m2  = idx_q - CNT_W'(2);
	assign idx_p1  = idx_q + CNT_W'(1);
	assign idx_p2  = idx_q + CNT_W'(2);

	// The shared comparator. Add and remove look for the first entry not
	// below the key; a query looks for the first entry above the address.
	assign rd_lt    = rd_data_q < key_q;
	assign rd_eq    = rd_data_q == key_q;
	assign go_right = rd_lt || ((cmd_q == CMD_QUERY) && rd_eq);

	// One range check serves both the recent chunk and the table candidate.
	assign chk_base = (state_q == S_START) ? recent_base_q : rd_data_q;
	assign chk_hit  = in_chunk(key_q, chk_base);

	// Memory port control. A read issued in one state returns its data in
	// the next; the moves read one entry ahead of the entry being written.
	always_comb begin
		rd_addr = mid[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data_q;
		unique case (state_q)
			S_RESOLVE: begin
				case (cmd_q)
					CMD_ADD:    rd_addr = cnt_m1[IDX_W-1:0];
					CMD_REMOVE: rd_addr = lo_q[IDX_W-1:0];
					default:    rd_addr = lo_m1[IDX_W-1:0];
				endcase
			end
			S_RMCHK: begin
				rd_addr = lo_p1[IDX_W-1:0];
			end
			S_SHDN: begin
				wr_en   = 1'b1;
				rd_addr = idx_m2[IDX_W-1:0];
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[IDX_W-1:0];
				wr_data = key_q;
			end
			S_SHUP: begin
				wr_en   = 1'b1;
				rd_addr = idx_p2[IDX_W-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_total = rsp_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			recent_base_q  <= '0;
			recent_valid_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			// A taken result is dropped here unless the done state loads the
			// next one in the same cycle.
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.cmd;
						key_q        <= req.addr;
						lo_q         <= '0;
						hi_q         <= count_q;
						res_hit_q    <= 1'b0;
						res_status_q <= STS_OK;
						state_q      <= S_START;
					end
				end
				S_START: begin
					unique case (cmd_q)
						CMD_ADD: begin
							if (count_q == CNT_W'(MAX_CHUNKS)) begin
								res_status_q <= STS_FULL;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_SRCH;
							end
						end
						CMD_REMOVE: begin
							state_q <= S_SRCH;
						end
						CMD_QUERY: begin
							if (recent_valid_q && chk_hit) begin
								res_hit_q <= 1'b1;
								state_q   <= S_DONE;
							end else begin
								state_q <= S_SRCH;
							end
						end
						CMD_NOP: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SRCH: begin
					state_q <= (lo_q < hi_q) ? S_CMP : S_RESOLVE;
				end
				S_CMP: begin
					if (go_right) begin
						lo_q <= mid_p1;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_RESOLVE: begin
					case (cmd_q)
						CMD_ADD: begin
							if (count_q > lo_q) begin
								idx_q   <= count_q;
								state_q <= S_SHDN;
							end else begin
								state_q <= S_INS;
							end
						end
						CMD_REMOVE: begin
							if (lo_q < count_q) begin
								state_q <= S_RMCHK;
							end else begin
								res_status_q <= STS_NOT_FOUND;
								state_q      <= S_DONE;
							end
						end
						default: begin
							state_q <= (lo_q == '0) ? S_DONE : S_QCHK;
						end
					endcase
				end
				S_QCHK: begin
					if (chk_hit) begin
						res_hit_q      <= 1'b1;
						recent_base_q  <= rd_data_q;
						recent_valid_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_RMCHK: begin
					if (rd_eq) begin
						idx_q <= lo_q;
						if (lo_p1 < count_q) begin
							state_q <= S_SHUP;
						end else begin
							count_q <= cnt_m1;
							state_q <= S_DONE;
						end
					end else begin
						res_status_q <= STS_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				S_SHDN: begin
					idx_q <= idx_m1;
					if (idx_m1 <= lo_q) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SHUP: begin
					idx_q <= idx_p1;
					if (idx_p2 >= count_q) begin
						count_q <= cnt_m1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_hit_q    <= res_hit_q;
						rsp_status_q <= res_status_q;
						rsp_total_q  <= TOTAL_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/srr_checker.sv
module srr_checker
	import srr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_hit,
	input logic [1:0]         rsp_status,
	input logic [TOTAL_W-1:0] rsp_entry_total
);

	// A result that is not taken stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
		$stable(rsp_status) && $stable(rsp_entry_total))
		else $error("rsp item changed while stalled");

	// The table never reports more chunks than it can hold.
	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_total <= TOTAL_W'(MAX_CHUNKS))
		else $error("entry_total above table size");

	// A hit only comes from a query, which always reports ok.
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> rsp_status == STS_OK)
		else $error("hit with nonzero status");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req accepted on back-to-back cycles");

endmodule

bind sorted_range_registry_core srr_checker u_srr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_hit         (rsp.hit),
	.rsp_status      (rsp.status),
	.rsp_entry_total (rsp.entry_total)
);
